### rtl/frx_pkg.sv
package frx_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 32;
    localparam logic [7:0]  SYNC_RESET      = 8'hAA;
    localparam logic [7:0]  CRC_POLY        = 8'h8C;
    localparam int unsigned FIELD_LEN_W     = 6;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CRC,
        PH_READ
    } t_frx_phase;

    // reflected CRC-8, one byte folded in
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/frx_if.sv
interface frx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_type;
    logic [5:0] frame_length;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output frame_type, output frame_length,
                    output payload_byte, output byte_valid, output last, input ready);
    modport sink   (input valid, input frame_type, input frame_length,
                    input payload_byte, input byte_valid, input last, output ready);
endinterface

### rtl/sync_length_crc8_frame_receiver_top.sv
// Framed packet receiver with CRC-8 check (reflected, polynomial 0x8C, init 0).
// Input channel i_rx: one received byte per transfer. A frame is sync byte,
// type, length, payload, CRC byte; the CRC covers type, length and payload.
// Output channel o_res: one transfer per payload byte of a frame whose CRC
// matches, last marked; an empty frame gives one transfer with byte_valid low.
// Bad CRC or an oversized length drops the frame silently.
// i_cfg_we/i_cfg_wdata write the sync byte value (reset 0xAA); write it idle.
// Throughput: one byte a cycle while a frame is parsed. After a good CRC byte
// input is held off while the frame is read out of the payload memory through
// its single read port, one read per payload byte (one result for an empty
// frame), and for as long as the output stalls. The first result is shown once
// the parser has registered the readout phase and the memory read register is loaded.
// A stalled output holds its result; further results wait for it.
// Reset (synchronous) returns to waiting for sync and empties the output; the
// payload memory is not cleared, as each entry is written before it is read.
module sync_length_crc8_frame_receiver_top #(
    parameter int unsigned MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    frx_byte_if.sink     i_rx,
    frx_result_if.source o_res
);
    import frx_pkg::*;

    localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]        r_sync_value;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    logic              go;
    logic              done;
    logic [7:0]        ftype;
    logic [LEN_W-1:0]  flen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync_value <= i_cfg_wdata;
        end
    end

    frx_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W),
        .LEN_W       (LEN_W)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sync_value (r_sync_value),
        .s_rx         (i_rx),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_go         (go),
        .o_type       (ftype),
        .o_len        (flen),
        .i_done       (done)
    );

    frx_mem #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    frx_reader #(
        .ADDR_W (ADDR_W),
        .LEN_W  (LEN_W)
    ) u_reader (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_type  (ftype),
        .i_len   (flen),
        .o_done  (done),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .m_res   (o_res)
    );

endmodule

### rtl/frx_mem.sv
module frx_mem #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/frx_parser.sv
module frx_parser #(
    parameter int unsigned MAX_PAYLOAD = 32,
    parameter int unsigned ADDR_W      = 5,
    parameter int unsigned LEN_W       = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_sync_value,
    frx_byte_if.sink          s_rx,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [7:0]        o_wdata,
    output logic              o_go,
    output logic [7:0]        o_type,
    output logic [LEN_W-1:0]  o_len,
    input  logic              i_done
);
    import frx_pkg::*;

    t_frx_phase       r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [7:0]       r_crc, n_crc;
    logic             take;
    logic [7:0]       b;
    logic [7:0]       crc_next;
    logic [LEN_W-1:0] fill_inc;
    logic             len_bad;

    assign b        = s_rx.rx_byte;
    assign take     = s_rx.valid && s_rx.ready;
    assign crc_next = crc8_byte(r_crc, b);
    assign fill_inc = r_fill + LEN_W'(1);
    assign len_bad  = b > 8'(MAX_PAYLOAD);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC: if (take && b == i_sync_value) n_phase = PH_TYPE;
            PH_TYPE: if (take) n_phase = PH_LEN;
            PH_LEN: begin
                if (take) begin
                    if (len_bad) begin
                        n_phase = PH_SYNC;
                    end else if (b == 8'd0) begin
                        n_phase = PH_CRC;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: if (take && fill_inc >= r_len) n_phase = PH_CRC;
            PH_CRC: begin
                if (take) begin
                    if (r_crc == b) begin
                        n_phase = PH_READ;
                    end else if (b == i_sync_value) begin
                        n_phase = PH_TYPE;
                    end else begin
                        n_phase = PH_SYNC;
                    end
                end
            end
            PH_READ: if (i_done) n_phase = PH_SYNC;
            default: n_phase = PH_SYNC;
        endcase
    end

    always_comb begin
        n_type  = r_type;
        n_len   = r_len;
        n_fill  = r_fill;
        n_crc   = r_crc;
        o_we    = 1'b0;
        o_waddr = r_fill[ADDR_W-1:0];
        o_wdata = b;
        unique case (r_phase)
            PH_SYNC: begin
                n_fill = '0;
                n_crc  = '0;
            end
            PH_TYPE: begin
                if (take) begin
                    n_type = b;
                    n_crc  = crc_next;
                end
            end
            PH_LEN: begin
                if (take) begin
                    n_len  = LEN_W'(b);
                    n_crc  = len_bad ? 8'd0 : crc_next;
                    n_fill = '0;
                end
            end
            PH_DATA: begin
                if (take) begin
                    o_we   = 1'b1;
                    n_crc  = crc_next;
                    n_fill = fill_inc;
                end
            end
            PH_CRC: begin
                // restart the check for a frame that opens on this byte
                if (take && r_crc != b) begin
                    n_crc  = '0;
                    n_fill = '0;
                end
            end
            PH_READ: begin
                n_crc  = '0;
                n_fill = '0;
            end
            default: begin
                n_crc  = '0;
                n_fill = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_fill  <= '0;
            r_crc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_len  <= n_len;
    end

    // hold off input while the frame is read out
    assign s_rx.ready = (r_phase != PH_READ);
    assign o_go       = (r_phase == PH_READ);
    assign o_type     = r_type;
    assign o_len      = r_len;

endmodule

### rtl/frx_reader.sv
module frx_reader #(
    parameter int unsigned ADDR_W = 5,
    parameter int unsigned LEN_W  = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [7:0]        i_type,
    input  logic [LEN_W-1:0]  i_len,
    output logic              o_done,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    frx_result_if.source      m_res
);
    import frx_pkg::*;

    logic             r_valid;
    logic [7:0]       r_type;
    logic [5:0]       r_len;
    logic             r_bv;
    logic             r_last;
    logic [LEN_W-1:0] r_idx;
    logic             load;
    logic             empty;
    logic             is_last;
    logic [LEN_W-1:0] idx_inc;

    assign empty   = (i_len == '0);
    assign idx_inc = r_idx + LEN_W'(1);
    assign is_last = empty || (idx_inc == i_len);
    // memory read register doubles as the output payload register
    assign load    = i_go && (!r_valid || m_res.ready);
    assign o_re    = load && !empty;
    assign o_raddr = r_idx[ADDR_W-1:0];
    assign o_done  = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? '0 : idx_inc;
        end else if (m_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_type <= i_type;
            r_len  <= empty ? 6'd0 : FIELD_LEN_W'(i_len);
            r_bv   <= !empty;
            r_last <= is_last;
        end
    end

    assign m_res.valid        = r_valid;
    assign m_res.frame_type   = r_type;
    assign m_res.frame_length = r_len;
    assign m_res.payload_byte = r_bv ? i_rdata : 8'd0;
    assign m_res.byte_valid   = r_bv;
    assign m_res.last         = r_last;

endmodule

### rtl/frx_checker.sv
module frx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_bv,
    input logic       i_out_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_bv |-> i_out_last)
        else $error("empty frame result not marked last");

    // input is held off while a frame is still being read out
    a_readout_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken during frame readout");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

endmodule

bind sync_length_crc8_frame_receiver_top frx_checker u_frx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_byte  (o_res.payload_byte),
    .i_out_bv    (o_res.byte_valid),
    .i_out_last  (o_res.last)
);

### dv/tb_sync_length_crc8_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_sync_length_crc8_frame_receiver_top;
    import frx_pkg::*;

    localparam int unsigned MAX_PL         = MAX_PAYLOAD_DEF;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_BYTES    = 44;

    typedef struct packed {
        logic [7:0] ftype;
        logic [5:0] flen;
        logic [7:0] pbyte;
        logic       bvalid;
        logic       last;
    } t_payload_item;

    typedef enum logic [1:0] {
        CRC_GOOD,
        CRC_BAD,
        CRC_AS_SYNC
    } t_crc_mode;

    class frame_payload_scoreboard;
        t_frx_phase    phase;
        logic [7:0]    sync_byte;
        logic [7:0]    held_type;
        logic [5:0]    held_len;
        int unsigned   fill_count;
        logic [7:0]    crc_acc;
        logic [7:0]    payload_mem [MAX_PL];
        t_payload_item pending_payload [$];
        int unsigned   mismatches;
        int unsigned   checked;

        function new();
            sync_byte  = SYNC_RESET;
            mismatches = 0;
            checked    = 0;
            restart(1'b0);
        endfunction

        static function logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void restart(input bit synced);
            phase      = synced ? PH_TYPE : PH_SYNC;
            held_type  = '0;
            held_len   = '0;
            fill_count = 0;
            crc_acc    = '0;
        endfunction

        function void take_rx_byte(input logic [7:0] b);
            t_payload_item item;
            case (phase)
                PH_TYPE: begin
                    held_type = b;
                    crc_acc   = crc_fold(crc_acc, b);
                    phase     = PH_LEN;
                end
                PH_LEN: begin
                    if (b > MAX_PL) begin
                        restart(1'b0);
                    end else begin
                        held_len   = b[5:0];
                        crc_acc    = crc_fold(crc_acc, b);
                        fill_count = 0;
                        phase      = (b == 0) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (fill_count < MAX_PL) payload_mem[fill_count] = b;
                    crc_acc = crc_fold(crc_acc, b);
                    fill_count++;
                    if (fill_count >= held_len) phase = PH_CRC;
                end
                PH_CRC: begin
                    if (crc_acc == b) begin
                        item.ftype = held_type;
                        if (held_len == 0) begin
                            item.flen   = '0;
                            item.pbyte  = '0;
                            item.bvalid = 1'b0;
                            item.last   = 1'b1;
                            pending_payload.push_back(item);
                        end else begin
                            for (int i = 0; i < held_len && i < MAX_PL; i++) begin
                                item.flen   = held_len;
                                item.pbyte  = payload_mem[i];
                                item.bvalid = 1'b1;
                                item.last   = (i + 1 == held_len);
                                pending_payload.push_back(item);
                            end
                        end
                        restart(1'b0);
                    end else begin
                        // a bad CRC byte equal to the sync value opens a new frame
                        restart(b == sync_byte);
                    end
                end
                default: begin
                    if (b == sync_byte) restart(1'b1);
                end
            endcase
        endfunction

        function void check_payload_out(input t_payload_item got);
            t_payload_item want;
            if (pending_payload.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: type %h len %0d byte %h bv %b last %b",
                         $time, got.ftype, got.flen, got.pbyte, got.bvalid, got.last);
                return;
            end
            want = pending_payload.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                $display("%0t: mismatch: expected type %h len %0d byte %h bv %b last %b",
                         $time, want.ftype, want.flen, want.pbyte, want.bvalid, want.last);
                $display("%0t:           actual   type %h len %0d byte %h bv %b last %b",
                         $time, got.ftype, got.flen, got.pbyte, got.bvalid, got.last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    frx_byte_if   rx_if ();
    frx_result_if res_if ();

    sync_length_crc8_frame_receiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    frame_payload_scoreboard sb = new();

    bit          gaps_on;
    bit          stall_on;
    bit          last_part;
    logic [7:0]  sync_now;
    logic [7:0]  frame_body [$];
    logic [7:0]  sync_plan [4];
    int unsigned sent_bytes;
    int unsigned noise_bytes;
    int unsigned accepted_bytes;
    int unsigned frames_sent;
    int unsigned sync_writes;
    int unsigned idle_cycles;
    int unsigned phase_start;

    always #1 i_clk = ~i_clk;

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                sb.take_rx_byte(rx_if.rx_byte);
                accepted_bytes++;
            end
            if (res_if.valid && res_if.ready) begin
                sb.check_payload_out({res_if.frame_type, res_if.frame_length,
                                      res_if.payload_byte, res_if.byte_valid, res_if.last});
            end
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("sync_length_crc8_frame_receiver_top regression: fail");
                $finish;
            end
        end
    end

    // result back-pressure in short bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (stall_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            res_if.ready <= (stall_left == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_noise(input int unsigned count);
        logic [7:0] v;
        repeat (count) begin
            do v = 8'($urandom_range(0, 255)); while (v == sync_now);
            send_byte(v);
            noise_bytes++;
        end
    endtask

    task automatic fill_body(input int unsigned n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // frame_body supplies the payload; a length over the maximum ends the frame early
    task automatic send_frame(input bit with_sync, input logic [7:0] ftype,
                              input logic [7:0] len_byte, input t_crc_mode mode);
        logic [7:0] crc;
        crc = '0;
        frames_sent++;
        if (with_sync) send_byte(sync_now);
        send_byte(ftype);
        crc = frame_payload_scoreboard::crc_fold(crc, ftype);
        send_byte(len_byte);
        if (len_byte > MAX_PL) return;
        crc = frame_payload_scoreboard::crc_fold(crc, len_byte);
        for (int i = 0; i < len_byte; i++) begin
            send_byte(frame_body[i]);
            crc = frame_payload_scoreboard::crc_fold(crc, frame_body[i]);
        end
        case (mode)
            CRC_GOOD:    send_byte(crc);
            CRC_BAD:     send_byte(crc ^ (8'h01 << $urandom_range(0, 7)));
            CRC_AS_SYNC: send_byte(sync_now);
            default:     send_byte(crc);
        endcase
    endtask

    // wait past the monitor's view of the last input edge, then for the results
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_payload.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.sync_byte = v;
        sync_now     = v;
        sync_writes++;
    endtask

    task automatic run_directed();
        // bytes ignored while hunting for sync
        send_noise(1);
        send_byte(8'h00);
        send_byte(8'hFF);
        noise_bytes += 2;
        // empty frame
        send_frame(1'b1, 8'hFF, 8'd0, CRC_GOOD);
        // length one past the maximum
        send_frame(1'b1, 8'h00, 8'(MAX_PL + 1), CRC_GOOD);
        // bad CRC byte equal to sync, then a frame with no sync of its own
        frame_body.delete();
        frame_body.push_back(8'h3C);
        send_frame(1'b1, 8'h5A, 8'd1, CRC_AS_SYNC);
        send_frame(1'b0, 8'h01, 8'd0, CRC_GOOD);
        // payload extremes, then an empty frame with a bad CRC
        frame_body.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        send_frame(1'b1, 8'h00, 8'd2, CRC_GOOD);
        send_frame(1'b1, 8'h80, 8'd0, CRC_BAD);
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned len;
        gaps_on  = !last_part && ($urandom_range(0, 3) != 0);
        stall_on = !last_part && ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) len = MAX_PL;
        else if (pick == 1) len = $urandom_range(0, MAX_PL);
        else len = $urandom_range(0, 6);
        fill_body(len);
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            send_frame(1'b1, 8'($urandom_range(0, 255)), 8'(len), CRC_GOOD);
        end else if (pick < 75) begin
            send_frame(1'b1, 8'($urandom_range(0, 255)), 8'(len), CRC_BAD);
        end else if (pick < 82) begin
            send_frame(1'b1, 8'($urandom_range(0, 255)), 8'(len), CRC_AS_SYNC);
            fill_body($urandom_range(0, 4));
            send_frame(1'b0, 8'($urandom_range(0, 255)), 8'(frame_body.size()), CRC_GOOD);
        end else if (pick < 90) begin
            send_frame(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(MAX_PL + 1, 255)),
                       CRC_GOOD);
        end else begin
            send_noise($urandom_range(1, 4));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        gaps_on        = 1'b1;
        stall_on       = 1'b1;
        last_part      = 1'b0;
        sync_now       = SYNC_RESET;
        sent_bytes     = 0;
        noise_bytes    = 0;
        accepted_bytes = 0;
        frames_sent    = 0;
        sync_writes    = 0;
        idle_cycles    = 0;
        sync_plan[0]   = 8'h00;
        sync_plan[1]   = 8'hFF;
        sync_plan[2]   = 8'($urandom_range(1, 254));
        sync_plan[3]   = SYNC_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int ph = 0; ph < 4; ph++) begin
            write_sync(sync_plan[ph]);
            last_part   = (ph == 3);
            phase_start = sent_bytes - noise_bytes;
            while (sent_bytes - noise_bytes - phase_start < PHASE_BYTES) random_frame();
        end

        wait_drained();
        repeat (MAX_PL + 8) @(posedge i_clk);
        if (sb.pending_payload.size() != 0) begin
            sb.mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_payload.size());
        end
        $display("covered %0d bytes (%0d ignored noise) in %0d frames, %0d results checked",
                 accepted_bytes, noise_bytes, frames_sent, sb.checked);
        $display("sync value written %0d times, including 0x00, 0xFF and the reset value",
                 sync_writes);
        if (sb.mismatches == 0) begin
            $display("sync_length_crc8_frame_receiver_top regression: pass");
        end else begin
            $display("sync_length_crc8_frame_receiver_top regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/frx_pkg.sv
rtl/frx_if.sv
rtl/frx_mem.sv
rtl/frx_parser.sv
rtl/frx_reader.sv
rtl/sync_length_crc8_frame_receiver_top.sv
rtl/frx_checker.sv
dv/tb_sync_length_crc8_frame_receiver_top.sv
